@@ src/tfe_pkg.sv @@
// Shared constants and the command record of the telemetry frame encoder.
package tfe_pkg;

   localparam int COUNT_W = 16;
   localparam int BYTE_W  = 8;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hAA;

   // One accepted item, classified: which bytes the back end must emit.
   typedef struct packed {
      logic                 hdr;
      logic [COUNT_W-1:0]   requested_count;
      logic [COUNT_W-1:0]   payload_length;
      logic                 has_byte;
      logic [BYTE_W-1:0]    data;
      logic                 has_chk;
      logic [BYTE_W-1:0]    chk;
   } tfe_cmd_type;

endpackage

@@ src/tfe_if.sv @@
// Request and response channel interfaces of the telemetry frame encoder.
interface tfe_req_if import tfe_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               start_req;
   logic [COUNT_W-1:0] requested_count;
   logic [COUNT_W-1:0] payload_length;
   logic [BYTE_W-1:0]  payload_byte;

   modport source (output valid, start_req, requested_count, payload_length, payload_byte,
                   input ready);
   modport sink (input valid, start_req, requested_count, payload_length, payload_byte,
                 output ready);
endinterface

interface tfe_rsp_if import tfe_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last_of_frame;

   modport source (output valid, out_byte, last_of_frame, input ready);
   modport sink (input valid, out_byte, last_of_frame, output ready);
endinterface

@@ src/telemetry_frame_encoder.sv @@
// Telemetry frame encoder top level: front end, command queue and back end.
//
// Request channel (req_bus): one beat per item. A beat with start_req set opens a
// frame, carrying requested_count, payload_length and the first payload byte;
// later beats carry one payload byte each. Payload beats outside a frame are
// taken and dropped.
// Response channel (rsp_bus): the packet stream, one byte per beat: sync 0xAA,
// requested count, payload length (high bytes first), payload bytes, then the
// XOR checksum of all earlier bytes with last_of_frame set.
// Throughput: one response byte per cycle while rsp_bus.ready is high and a command is
// queued. A start beat yields 6 or 7 bytes, a payload beat 1 or 2; the back end's byte
// sequencer sets the rate, and the command queue (QueueDepth entries) lets requests run
// ahead of it so that request beats are taken every cycle while the queue has room.
// With the queue empty, an item's request beat is written into the queue, and its first
// byte is then loaded from the queue head into the output register that drives rsp_bus.
// Stall: while rsp_bus.ready is low the output register holds its byte, the
// queue fills, and req_bus.ready falls once it is full.
// Reset (synchronous, active high) empties the queue, closes any open frame and
// clears the running checksum.
module telemetry_frame_encoder import tfe_pkg::*; #(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   tfe_req_if.sink   req_bus,
   tfe_rsp_if.source rsp_bus
);

   tfe_cmd_type push_cmd;
   tfe_cmd_type head_cmd;
   logic        push;
   logic        pop;
   logic        q_full;
   logic        q_empty;

   tfe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .q_full   (q_full),
      .push     (push),
      .push_cmd (push_cmd)
   );

   tfe_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   tfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .head_valid (!q_empty),
      .pop        (pop),
      .rsp        (rsp_bus)
   );

`ifndef ASSERT_OFF
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_bus.valid)
      else $error("response valid after reset");

   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_full && q_empty))
      else $error("queue both full and empty");

   a_start_queued: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && req_bus.start_req) |=> !q_empty)
      else $error("start beat not queued");
`endif

endmodule

@@ src/tfe_front.sv @@
// Front end: accepts request beats, tracks frame state and builds commands.
module tfe_front import tfe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   tfe_req_if.sink     req,
   input  logic        q_full,
   output logic        push,
   output tfe_cmd_type push_cmd
);

   logic [BYTE_W-1:0]  running_xor_ff, running_xor_in;
   logic [COUNT_W-1:0] bytes_left_ff, bytes_left_in;
   logic               in_frame_ff, in_frame_in;

   logic               accept;
   logic               active;
   logic               len_zero;
   logic               has_byte;
   logic               has_chk;
   logic [COUNT_W-1:0] left_after;
   logic [BYTE_W-1:0]  hdr_xor;
   logic [BYTE_W-1:0]  xor_pre;
   logic [BYTE_W-1:0]  xor_all;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign active    = in_frame_ff && (bytes_left_ff != '0);
   assign len_zero  = (req.payload_length == '0);

   assign hdr_xor = SYNC_BYTE
                  ^ req.requested_count[15:8] ^ req.requested_count[7:0]
                  ^ req.payload_length[15:8]  ^ req.payload_length[7:0];

   always_comb begin
      if (req.start_req) begin
         has_byte   = !len_zero;
         left_after = req.payload_length - 1'b1;
         xor_pre    = hdr_xor;
      end else begin
         has_byte   = 1'b1;
         left_after = bytes_left_ff - 1'b1;
         xor_pre    = running_xor_ff;
      end
      has_chk = (req.start_req && len_zero) || (left_after == '0);
      xor_all = xor_pre ^ (has_byte ? req.payload_byte : '0);

      push = accept && (req.start_req || active);

      push_cmd.hdr             = req.start_req;
      push_cmd.requested_count = req.requested_count;
      push_cmd.payload_length  = req.payload_length;
      push_cmd.has_byte        = has_byte;
      push_cmd.data            = req.payload_byte;
      push_cmd.has_chk         = has_chk;
      push_cmd.chk             = xor_all;

      running_xor_in = running_xor_ff;
      bytes_left_in  = bytes_left_ff;
      in_frame_in    = in_frame_ff;
      // Payload beats outside a frame fall through here and are dropped.
      if (push) begin
         running_xor_in = has_chk ? '0 : xor_all;
         bytes_left_in  = (req.start_req && len_zero) ? '0 : left_after;
         in_frame_in    = !has_chk;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_xor_ff <= '0;
         bytes_left_ff  <= '0;
         in_frame_ff    <= 1'b0;
      end else begin
         running_xor_ff <= running_xor_in;
         bytes_left_ff  <= bytes_left_in;
         in_frame_ff    <= in_frame_in;
      end
   end

endmodule

@@ src/tfe_queue.sv @@
// Short command queue between the front and back ends.
module tfe_queue import tfe_pkg::*; #(
   parameter int Depth = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  tfe_cmd_type push_cmd,
   input  logic        pop,
   output tfe_cmd_type head_cmd,
   output logic        full,
   output logic        empty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   tfe_cmd_type       slot_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full     = (count_ff == CntW'(Depth));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ src/tfe_back.sv @@
// Back end: serialises queued commands into response beats, one byte a cycle while rsp.ready is high.
module tfe_back import tfe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  tfe_cmd_type head_cmd,
   input  logic        head_valid,
   output logic        pop,
   tfe_rsp_if.source   rsp
);

   typedef enum logic [2:0] {
      ST_SYNC,
      ST_REQ_HI,
      ST_REQ_LO,
      ST_LEN_HI,
      ST_LEN_LO,
      ST_DATA,
      ST_CHK
   } step_type;

   step_type          step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              last_ff, last_in;

   step_type          cur_step;
   step_type          next_step;
   logic              done;
   logic              load;

   assign load = head_valid && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      if (busy_ff) begin
         cur_step = step_ff;
      end else if (head_cmd.hdr) begin
         cur_step = ST_SYNC;
      end else if (head_cmd.has_byte) begin
         cur_step = ST_DATA;
      end else begin
         cur_step = ST_CHK;
      end

      out_byte_in = out_byte_ff;
      last_in     = 1'b0;
      next_step   = ST_SYNC;
      done        = 1'b1;
      unique case (cur_step)
         ST_SYNC: begin
            out_byte_in = SYNC_BYTE;
            next_step   = ST_REQ_HI;
            done        = 1'b0;
         end
         ST_REQ_HI: begin
            out_byte_in = head_cmd.requested_count[15:8];
            next_step   = ST_REQ_LO;
            done        = 1'b0;
         end
         ST_REQ_LO: begin
            out_byte_in = head_cmd.requested_count[7:0];
            next_step   = ST_LEN_HI;
            done        = 1'b0;
         end
         ST_LEN_HI: begin
            out_byte_in = head_cmd.payload_length[15:8];
            next_step   = ST_LEN_LO;
            done        = 1'b0;
         end
         ST_LEN_LO: begin
            out_byte_in = head_cmd.payload_length[7:0];
            next_step   = head_cmd.has_byte ? ST_DATA : ST_CHK;
            done        = !head_cmd.has_byte && !head_cmd.has_chk;
         end
         ST_DATA: begin
            out_byte_in = head_cmd.data;
            next_step   = ST_CHK;
            done        = !head_cmd.has_chk;
         end
         ST_CHK: begin
            out_byte_in = head_cmd.chk;
            last_in     = 1'b1;
         end
         default: begin
            out_byte_in = head_cmd.chk;
         end
      endcase

      pop          = load && done;
      busy_in      = busy_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (load) begin
         busy_in      = !done;
         step_in      = next_step;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_SYNC;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load) begin
         out_byte_ff <= out_byte_in;
         last_ff     <= last_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.out_byte      = out_byte_ff;
   assign rsp.last_of_frame = last_ff;

endmodule
